// File: rtl/sm4g_pkg.sv
// ----------------------------------------------------------------------------
// sm4g_pkg
// Shared types, constants and functions of the SM4-GCM engine.
// ----------------------------------------------------------------------------
package sm4g_pkg;

  localparam int BLK_W  = 128;
  localparam int WORD_W = 32;
  localparam int ROUNDS = 32;
  localparam int CFG_W  = 64;
  localparam int CFG_IDX_W = 3;
  localparam int DIGIT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT    = 3'd4;

  localparam logic [1:0] ACT_START  = 2'd0;
  localparam logic [1:0] ACT_AAD    = 2'd1;
  localparam logic [1:0] ACT_TEXT   = 2'd2;
  localparam logic [1:0] ACT_FINISH = 2'd3;

  localparam logic [7:0] GCM_R = 8'he1;
  localparam logic [127:0] FK = 128'hA3B1BAC6_56AA3350_677D9197_B27022DC;

  // control from sequencer to the cipher core
  typedef struct packed {
    logic load;      // load block into datapath
    logic key_mode;  // key expansion round instead of data round
    logic step;      // do one round
  } sm4g_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'hd6; 8'h01: r=8'h90; 8'h02: r=8'he9; 8'h03: r=8'hfe;
      8'h04: r=8'hcc; 8'h05: r=8'he1; 8'h06: r=8'h3d; 8'h07: r=8'hb7;
      8'h08: r=8'h16; 8'h09: r=8'hb6; 8'h0a: r=8'h14; 8'h0b: r=8'hc2;
      8'h0c: r=8'h28; 8'h0d: r=8'hfb; 8'h0e: r=8'h2c; 8'h0f: r=8'h05;
      8'h10: r=8'h2b; 8'h11: r=8'h67; 8'h12: r=8'h9a; 8'h13: r=8'h76;
      8'h14: r=8'h2a; 8'h15: r=8'hbe; 8'h16: r=8'h04; 8'h17: r=8'hc3;
      8'h18: r=8'haa; 8'h19: r=8'h44; 8'h1a: r=8'h13; 8'h1b: r=8'h26;
      8'h1c: r=8'h49; 8'h1d: r=8'h86; 8'h1e: r=8'h06; 8'h1f: r=8'h99;
      8'h20: r=8'h9c; 8'h21: r=8'h42; 8'h22: r=8'h50; 8'h23: r=8'hf4;
      8'h24: r=8'h91; 8'h25: r=8'hef; 8'h26: r=8'h98; 8'h27: r=8'h7a;
      8'h28: r=8'h33; 8'h29: r=8'h54; 8'h2a: r=8'h0b; 8'h2b: r=8'h43;
      8'h2c: r=8'hed; 8'h2d: r=8'hcf; 8'h2e: r=8'hac; 8'h2f: r=8'h62;
      8'h30: r=8'he4; 8'h31: r=8'hb3; 8'h32: r=8'h1c; 8'h33: r=8'ha9;
      8'h34: r=8'hc9; 8'h35: r=8'h08; 8'h36: r=8'he8; 8'h37: r=8'h95;
      8'h38: r=8'h80; 8'h39: r=8'hdf; 8'h3a: r=8'h94; 8'h3b: r=8'hfa;
      8'h3c: r=8'h75; 8'h3d: r=8'h8f; 8'h3e: r=8'h3f; 8'h3f: r=8'ha6;
      8'h40: r=8'h47; 8'h41: r=8'h07; 8'h42: r=8'ha7; 8'h43: r=8'hfc;
      8'h44: r=8'hf3; 8'h45: r=8'h73; 8'h46: r=8'h17; 8'h47: r=8'hba;
      8'h48: r=8'h83; 8'h49: r=8'h59; 8'h4a: r=8'h3c; 8'h4b: r=8'h19;
      8'h4c: r=8'he6; 8'h4d: r=8'h85; 8'h4e: r=8'h4f; 8'h4f: r=8'ha8;
      8'h50: r=8'h68; 8'h51: r=8'h6b; 8'h52: r=8'h81; 8'h53: r=8'hb2;
      8'h54: r=8'h71; 8'h55: r=8'h64; 8'h56: r=8'hda; 8'h57: r=8'h8b;
      8'h58: r=8'hf8; 8'h59: r=8'heb; 8'h5a: r=8'h0f; 8'h5b: r=8'h4b;
      8'h5c: r=8'h70; 8'h5d: r=8'h56; 8'h5e: r=8'h9d; 8'h5f: r=8'h35;
      8'h60: r=8'h1e; 8'h61: r=8'h24; 8'h62: r=8'h0e; 8'h63: r=8'h5e;
      8'h64: r=8'h63; 8'h65: r=8'h58; 8'h66: r=8'hd1; 8'h67: r=8'ha2;
      8'h68: r=8'h25; 8'h69: r=8'h22; 8'h6a: r=8'h7c; 8'h6b: r=8'h3b;
      8'h6c: r=8'h01; 8'h6d: r=8'h21; 8'h6e: r=8'h78; 8'h6f: r=8'h87;
      8'h70: r=8'hd4; 8'h71: r=8'h00; 8'h72: r=8'h46; 8'h73: r=8'h57;
      8'h74: r=8'h9f; 8'h75: r=8'hd3; 8'h76: r=8'h27; 8'h77: r=8'h52;
      8'h78: r=8'h4c; 8'h79: r=8'h36; 8'h7a: r=8'h02; 8'h7b: r=8'he7;
      8'h7c: r=8'ha0; 8'h7d: r=8'hc4; 8'h7e: r=8'hc8; 8'h7f: r=8'h9e;
      8'h80: r=8'hea; 8'h81: r=8'hbf; 8'h82: r=8'h8a; 8'h83: r=8'hd2;
      8'h84: r=8'h40; 8'h85: r=8'hc7; 8'h86: r=8'h38; 8'h87: r=8'hb5;
      8'h88: r=8'ha3; 8'h89: r=8'hf7; 8'h8a: r=8'hf2; 8'h8b: r=8'hce;
      8'h8c: r=8'hf9; 8'h8d: r=8'h61; 8'h8e: r=8'h15; 8'h8f: r=8'ha1;
      8'h90: r=8'he0; 8'h91: r=8'hae; 8'h92: r=8'h5d; 8'h93: r=8'ha4;
      8'h94: r=8'h9b; 8'h95: r=8'h34; 8'h96: r=8'h1a; 8'h97: r=8'h55;
      8'h98: r=8'had; 8'h99: r=8'h93; 8'h9a: r=8'h32; 8'h9b: r=8'h30;
      8'h9c: r=8'hf5; 8'h9d: r=8'h8c; 8'h9e: r=8'hb1; 8'h9f: r=8'he3;
      8'ha0: r=8'h1d; 8'ha1: r=8'hf6; 8'ha2: r=8'he2; 8'ha3: r=8'h2e;
      8'ha4: r=8'h82; 8'ha5: r=8'h66; 8'ha6: r=8'hca; 8'ha7: r=8'h60;
      8'ha8: r=8'hc0; 8'ha9: r=8'h29; 8'haa: r=8'h23; 8'hab: r=8'hab;
      8'hac: r=8'h0d; 8'had: r=8'h53; 8'hae: r=8'h4e; 8'haf: r=8'h6f;
      8'hb0: r=8'hd5; 8'hb1: r=8'hdb; 8'hb2: r=8'h37; 8'hb3: r=8'h45;
      8'hb4: r=8'hde; 8'hb5: r=8'hfd; 8'hb6: r=8'h8e; 8'hb7: r=8'h2f;
      8'hb8: r=8'h03; 8'hb9: r=8'hff; 8'hba: r=8'h6a; 8'hbb: r=8'h72;
      8'hbc: r=8'h6d; 8'hbd: r=8'h6c; 8'hbe: r=8'h5b; 8'hbf: r=8'h51;
      8'hc0: r=8'h8d; 8'hc1: r=8'h1b; 8'hc2: r=8'haf; 8'hc3: r=8'h92;
      8'hc4: r=8'hbb; 8'hc5: r=8'hdd; 8'hc6: r=8'hbc; 8'hc7: r=8'h7f;
      8'hc8: r=8'h11; 8'hc9: r=8'hd9; 8'hca: r=8'h5c; 8'hcb: r=8'h41;
      8'hcc: r=8'h1f; 8'hcd: r=8'h10; 8'hce: r=8'h5a; 8'hcf: r=8'hd8;
      8'hd0: r=8'h0a; 8'hd1: r=8'hc1; 8'hd2: r=8'h31; 8'hd3: r=8'h88;
      8'hd4: r=8'ha5; 8'hd5: r=8'hcd; 8'hd6: r=8'h7b; 8'hd7: r=8'hbd;
      8'hd8: r=8'h2d; 8'hd9: r=8'h74; 8'hda: r=8'hd0; 8'hdb: r=8'h12;
      8'hdc: r=8'hb8; 8'hdd: r=8'he5; 8'hde: r=8'hb4; 8'hdf: r=8'hb0;
      8'he0: r=8'h89; 8'he1: r=8'h69; 8'he2: r=8'h97; 8'he3: r=8'h4a;
      8'he4: r=8'h0c; 8'he5: r=8'h96; 8'he6: r=8'h77; 8'he7: r=8'h7e;
      8'he8: r=8'h65; 8'he9: r=8'hb9; 8'hea: r=8'hf1; 8'heb: r=8'h09;
      8'hec: r=8'hc5; 8'hed: r=8'h6e; 8'hee: r=8'hc6; 8'hef: r=8'h84;
      8'hf0: r=8'h18; 8'hf1: r=8'hf0; 8'hf2: r=8'h7d; 8'hf3: r=8'hec;
      8'hf4: r=8'h3a; 8'hf5: r=8'hdc; 8'hf6: r=8'h4d; 8'hf7: r=8'h20;
      8'hf8: r=8'h79; 8'hf9: r=8'hee; 8'hfa: r=8'h5f; 8'hfb: r=8'h3e;
      8'hfc: r=8'hd7; 8'hfd: r=8'hcb; 8'hfe: r=8'h39; 8'hff: r=8'h48;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] tau(input logic [31:0] v);
    return {sbox(v[31:24]), sbox(v[23:16]), sbox(v[15:8]), sbox(v[7:0])};
  endfunction

  // CK word i: byte j is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [4:0] i);
    logic [7:0] b;
    logic [31:0] v;
    v = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'(({3'd0, i} * 8'd4 + 8'(j)) * 8'd7);
      v = {v[23:0], b};
    end
    return v;
  endfunction

  function automatic logic [63:0] lead_mask(input logic [3:0] n);
    logic [63:0] m;
    if (n == 4'd0) m = '0;
    else if (n >= 4'd8) m = '1;
    else m = ~64'd0 << (7'd64 - {n[2:0], 3'd0});
    return m;
  endfunction

endpackage

// File: rtl/sm4_gcm_authenticated_cipher_top.sv
// ----------------------------------------------------------------------------
// sm4_gcm_authenticated_cipher_top
// SM4-GCM engine, one 128-bit block per transaction.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                      | tuser
// in_     | in  | block_high, block_low, byte_count (136b)| action
// out_    | out | out_high, out_low (128b)                | is_tag, tag_match
// cfg_    | in  | write port, 3-bit index, 64-bit data    | -
//
// Steps: aad and finish run the GHASH launch, the digit steps, done, output;
// text first runs the SM4 rounds for the keystream, then the same GHASH
// tail, not overlapped; zero-count text and aad skip the GHASH multiply;
// start runs the key rounds, then H, then J0. One transaction at a time.
// Reset clears control state and the hash state registers.
// The result sits in an output register; in_tready drops until it is taken.
// ----------------------------------------------------------------------------
module sm4_gcm_authenticated_cipher_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_high, block_low, byte_count, pad
  input  logic [1:0]   in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // out_high, out_low
  output logic [1:0]   out_tuser,  // is_tag, tag_match
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_KEY   = 7'b0000010,
    S_HSUB  = 7'b0000100,
    S_J0    = 7'b0001000,
    S_TEXT  = 7'b0010000,
    S_HASH  = 7'b0100000,
    S_OUT   = 7'b1000000
  } st_t;

  st_t st_r, st_nxt;
  logic [63:0] key_hi_r, key_lo_r, non_hi_r;
  logic [31:0] non_lo_r;
  logic        dec_r;
  logic [127:0] h_r, acc_r, tm_r, blk_r, tag_exp_r, res_r;
  logic [31:0]  ctr_r;
  logic [63:0]  aad_tot_r, txt_tot_r;
  logic [1:0]   act_r;
  logic [4:0]   cnt_r;
  logic [5:0]   rnd_r, rnd_nxt;
  logic         ov_r, fin_r, gh_go;
  logic [1:0]   ou_r;
  logic [127:0] cblk_in, cblk_out, gh_a, gh_z, ks, mask;
  logic         gh_busy;
  logic [4:0]   sat;
  sm4g_pkg::sm4g_ctl_t ctl;

  assign sat  = (in_tdata[132:128] > 5'd16) ? 5'd16 : in_tdata[132:128];
  assign mask = {sm4g_pkg::lead_mask(cnt_r > 5'd8 ? 4'd8 : cnt_r[3:0]),
                 sm4g_pkg::lead_mask(cnt_r > 5'd8 ? 4'(cnt_r - 5'd8) : 4'd0)};

  assign in_tready = (st_r == S_IDLE) && !ov_r;

  sm4g_cipher u_cipher (
    .clk(clk), .ctl(ctl), .rnd(rnd_r[4:0]), .rd_rnd(rnd_nxt[4:0]),
    .blk_in(cblk_in), .blk_out(cblk_out)
  );

  sm4g_ghash u_ghash (
    .clk(clk), .rst_n(rst_n), .start(gh_go), .a_in(gh_a), .h_in(h_r),
    .busy(gh_busy), .z_out(gh_z)
  );

  assign ks = cblk_out;

  always_comb begin
    st_nxt = st_r; rnd_nxt = rnd_r;
    ctl = '0; cblk_in = '0; gh_go = 1'b0; gh_a = '0;
    case (st_r)
      S_IDLE: begin
        rnd_nxt = '0;
        if (in_tvalid && in_tready) begin
          case (in_tuser)
            sm4g_pkg::ACT_START: begin
              ctl.load = 1'b1; ctl.key_mode = 1'b1;
              cblk_in = {key_hi_r, key_lo_r} ^ sm4g_pkg::FK;
              st_nxt = S_KEY;
            end
            sm4g_pkg::ACT_TEXT: begin
              ctl.load = 1'b1;
              cblk_in = {non_hi_r, non_lo_r, ctr_r};
              st_nxt = S_TEXT;
            end
            default: st_nxt = S_HASH;
          endcase
        end
      end
      S_KEY, S_HSUB, S_J0, S_TEXT: begin
        ctl.key_mode = (st_r == S_KEY);
        if (rnd_r == 6'd32) begin
          rnd_nxt = '0;
          // keystream and J0 result stay in the datapath for capture
          case (st_r)
            S_KEY:  begin ctl.load = 1'b1; cblk_in = '0; st_nxt = S_HSUB; end
            S_HSUB: begin
              ctl.load = 1'b1; cblk_in = {non_hi_r, non_lo_r, 32'd1}; st_nxt = S_J0;
            end
            S_J0:   st_nxt = S_IDLE;
            default: st_nxt = S_HASH;
          endcase
          ctl.key_mode = 1'b0;
        end else begin
          ctl.step = 1'b1;
          rnd_nxt = rnd_r + 6'd1;
        end
      end
      S_HASH: begin
        if (rnd_r == 6'd0) begin
          rnd_nxt = 6'd1;
          case (act_r)
            sm4g_pkg::ACT_AAD: begin
              gh_go = (cnt_r != 5'd0); gh_a = acc_r ^ blk_r;
            end
            sm4g_pkg::ACT_TEXT: begin
              gh_go = (cnt_r != 5'd0);
              gh_a = acc_r ^ (dec_r ? blk_r : ((blk_r ^ ks) & mask));
            end
            default: begin
              gh_go = 1'b1; gh_a = acc_r ^ {aad_tot_r << 3, txt_tot_r << 3};
            end
          endcase
          if (!gh_go) st_nxt = S_OUT;
        end else if (!gh_busy) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; rnd_r <= '0; ov_r <= 1'b0;
      key_hi_r <= '0; key_lo_r <= '0; non_hi_r <= '0; non_lo_r <= '0; dec_r <= 1'b0;
      h_r <= '0; acc_r <= '0; tm_r <= '0; ctr_r <= '0;
      aad_tot_r <= '0; txt_tot_r <= '0; fin_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt;
      if (cfg_we) begin
        case (cfg_index)
          sm4g_pkg::REG_KEY_HIGH:   key_hi_r <= cfg_data;
          sm4g_pkg::REG_KEY_LOW:    key_lo_r <= cfg_data;
          sm4g_pkg::REG_NONCE_HIGH: non_hi_r <= cfg_data;
          sm4g_pkg::REG_NONCE_LOW:  non_lo_r <= cfg_data[31:0];
          sm4g_pkg::REG_DECRYPT:    dec_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) ov_r <= 1'b0;
      if (in_tvalid && in_tready) begin
        act_r <= in_tuser;
        cnt_r <= sat;
        // block_high sits in the low tdata bits; keep blocks big-endian inside
        blk_r <= {in_tdata[63:0], in_tdata[127:64]} &
                 {sm4g_pkg::lead_mask(sat > 5'd8 ? 4'd8 : sat[3:0]),
                  sm4g_pkg::lead_mask(sat > 5'd8 ? 4'(sat - 5'd8) : 4'd0)};
        tag_exp_r <= {in_tdata[63:0], in_tdata[127:64]};
      end
      if (st_r == S_HSUB && rnd_r == 6'd32) h_r <= cblk_out;
      if (st_r == S_J0 && rnd_r == 6'd32) begin
        tm_r <= cblk_out; acc_r <= '0; ctr_r <= 32'd2;
        aad_tot_r <= '0; txt_tot_r <= '0;
      end
      if (st_r == S_HASH && rnd_r == 6'd0) begin
        fin_r <= (act_r == sm4g_pkg::ACT_FINISH);
        if (act_r == sm4g_pkg::ACT_TEXT) begin
          res_r <= (blk_r ^ ks) & mask;
          if (cnt_r != 5'd0) begin
            ctr_r <= ctr_r + 32'd1;
            txt_tot_r <= txt_tot_r + {59'd0, cnt_r};
          end
        end else if (act_r == sm4g_pkg::ACT_AAD && cnt_r != 5'd0)
          aad_tot_r <= aad_tot_r + {59'd0, cnt_r};
      end
      if (st_r == S_OUT) begin
        if (gh_z != acc_r || 1'b1) begin
          if (act_r == sm4g_pkg::ACT_FINISH || cnt_r != 5'd0 &&
              act_r != sm4g_pkg::ACT_START)
            acc_r <= gh_z;
        end
        if (act_r == sm4g_pkg::ACT_TEXT) begin
          ov_r <= 1'b1; ou_r <= 2'b00;
        end else if (fin_r) begin
          ov_r <= 1'b1;
          res_r <= gh_z ^ tm_r;
          ou_r <= {dec_r && ((gh_z ^ tm_r) == tag_exp_r), 1'b1};
        end
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {res_r[63:0], res_r[127:64]};
  assign out_tuser  = ou_r;

endmodule

// File: rtl/sm4g_cipher.sv
// ----------------------------------------------------------------------------
// sm4g_cipher
// SM4 round engine: one round per cycle, key expansion or data rounds.
// Round keys kept in a local memory written during expansion.
// ----------------------------------------------------------------------------
module sm4g_cipher (
  input  logic                  clk,
  input  sm4g_pkg::sm4g_ctl_t   ctl,
  input  logic [4:0]            rnd,
  input  logic [4:0]            rd_rnd,
  input  logic [127:0]          blk_in,
  output logic [127:0]          blk_out
);

  logic [31:0]  rk_mem [sm4g_pkg::ROUNDS];
  logic [31:0]  rk_q;
  logic [127:0] w_r, w_nxt;
  logic [31:0]  t, nw, tv;

  // data round key is registered from rd_rnd, the round about to run
  always_ff @(posedge clk) begin
    rk_q <= rk_mem[rd_rnd];
    if (ctl.step && ctl.key_mode) rk_mem[rnd] <= nw;
  end

  always_comb begin
    t = w_r[95:64] ^ w_r[63:32] ^ w_r[31:0] ^
        (ctl.key_mode ? sm4g_pkg::ck_word(rnd) : rk_q);
    tv = sm4g_pkg::tau(t);
    if (ctl.key_mode)
      nw = w_r[127:96] ^ tv ^ {tv[18:0], tv[31:19]} ^ {tv[8:0], tv[31:9]};
    else
      nw = w_r[127:96] ^ tv ^ {tv[29:0], tv[31:30]} ^ {tv[21:0], tv[31:22]}
           ^ {tv[13:0], tv[31:14]} ^ {tv[7:0], tv[31:8]};
    w_nxt = w_r;
    if (ctl.load) w_nxt = blk_in;
    else if (ctl.step) w_nxt = {w_r[95:0], nw};
  end

  always_ff @(posedge clk) w_r <= w_nxt;

  assign blk_out = {w_r[31:0], w_r[63:32], w_r[95:64], w_r[127:96]};

endmodule

// File: rtl/sm4g_ghash.sv
// ----------------------------------------------------------------------------
// sm4g_ghash
// GF(2^128) multiply, 4 bits of the multiplicand per cycle.
// ----------------------------------------------------------------------------
module sm4g_ghash (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] a_in,
  input  logic [127:0] h_in,
  output logic         busy,
  output logic [127:0] z_out
);

  logic [127:0] a_r, a_nxt, v_r, v_nxt, z_r, z_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [127:0] v, z;

  always_comb begin
    a_nxt = a_r; v_nxt = v_r; z_nxt = z_r; cnt_nxt = cnt_r;
    v = v_r; z = z_r;
    if (start) begin
      a_nxt = a_in; v_nxt = h_in; z_nxt = '0; cnt_nxt = 6'd32;
    end else if (cnt_r != 6'd0) begin
      for (int i = 0; i < sm4g_pkg::DIGIT_W; i++) begin
        if (a_r[127-i]) z = z ^ v;
        v = {v[0] ? (1'b0 ^ 1'b0) : 1'b0, v[127:1]} ^
            (v[0] ? {sm4g_pkg::GCM_R, 120'd0} : 128'd0);
      end
      z_nxt = z; v_nxt = v;
      a_nxt = {a_r[123:0], 4'd0};
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; v_r <= v_nxt; z_r <= z_nxt;
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  assign busy = (cnt_r != 6'd0);
  assign z_out = z_r;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for the SM4-GCM engine. A scoreboard predicts every
// ciphertext block and tag from the accepted input transactions and checks
// them in order against the output channel, over several idling phases and
// register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 150;   // start has no result

  localparam bit [7:0] SUB [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct {
    bit [127:0] data;   // {out_high, out_low}
    bit         is_tag;
    bit         match;
  } gcm_result_t;

  int errors = 0;

  // Scoreboard: own copy of the engine state, queue of expected results
  class gcm_scoreboard;
    bit [127:0]  key, h_key, ghash, tmask;
    bit [95:0]   nonce;
    bit          decrypt;
    bit [31:0]   rk [32];
    bit [31:0]   ctr;
    bit [63:0]   aad_len, txt_len;
    gcm_result_t pending_q [$];

    function void write_reg(bit [2:0] idx, bit [63:0] val);
      case (idx)
        sm4g_pkg::REG_KEY_HIGH:   key[127:64]  = val;
        sm4g_pkg::REG_KEY_LOW:    key[63:0]    = val;
        sm4g_pkg::REG_NONCE_HIGH: nonce[95:32] = val;
        sm4g_pkg::REG_NONCE_LOW:  nonce[31:0]  = val[31:0];
        sm4g_pkg::REG_DECRYPT:    decrypt      = val[0];
        default: ;
      endcase
    endfunction

    function bit [31:0] rol(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function bit [31:0] subw(bit [31:0] v);
      return {SUB[v[31:24]], SUB[v[23:16]], SUB[v[15:8]], SUB[v[7:0]]};
    endfunction

    function void expand();
      bit [31:0] w [4];
      bit [31:0] ck, nk;
      bit [7:0]  b;
      w[0] = key[127:96] ^ 32'hA3B1BAC6;
      w[1] = key[95:64]  ^ 32'h56AA3350;
      w[2] = key[63:32]  ^ 32'h677D9197;
      w[3] = key[31:0]   ^ 32'hB27022DC;
      for (int i = 0; i < 32; i++) begin
        ck = 0;
        for (int j = 0; j < 4; j++) begin
          b = 8'(((4 * i + j) * 7) & 255);
          ck = {ck[23:0], b};
        end
        nk = subw(w[1] ^ w[2] ^ w[3] ^ ck);
        nk = w[0] ^ nk ^ rol(nk, 13) ^ rol(nk, 23);
        rk[i] = nk;
        w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = nk;
      end
    endfunction

    function bit [127:0] sm4_enc(bit [127:0] x);
      bit [31:0] w [4];
      bit [31:0] t;
      w[0] = x[127:96]; w[1] = x[95:64]; w[2] = x[63:32]; w[3] = x[31:0];
      for (int i = 0; i < 32; i++) begin
        t = subw(w[1] ^ w[2] ^ w[3] ^ rk[i]);
        t = w[0] ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
        w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = t;
      end
      return {w[3], w[2], w[1], w[0]};
    endfunction

    // GF(2^128) product, bit 0 of GCM is the msb
    function bit [127:0] gmul(bit [127:0] a, bit [127:0] b);
      bit [127:0] z, v;
      bit         lsb;
      z = 0; v = b;
      for (int i = 0; i < 128; i++) begin
        if (a[127-i]) z ^= v;
        lsb = v[0];
        v = v >> 1;
        if (lsb) v[127:120] ^= 8'he1;
      end
      return z;
    endfunction

    function bit [127:0] byte_mask(int n);
      return (n == 0) ? 128'd0 : ~128'd0 << (128 - 8 * n);
    endfunction

    // tag the engine would give on a finish right now
    function bit [127:0] next_tag();
      return gmul(ghash ^ {aad_len << 3, txt_len << 3}, h_key) ^ tmask;
    endfunction

    function void note_input(bit [1:0] act, bit [63:0] bh, bit [63:0] bl, bit [4:0] cnt_in);
      int          cnt;
      bit [127:0]  blk, ks, ct;
      gcm_result_t r;
      cnt = (cnt_in > 16) ? 16 : cnt_in;   // counts past 16 saturate
      blk = {bh, bl} & byte_mask(cnt);
      case (act)
        sm4g_pkg::ACT_START: begin
          expand();
          h_key = sm4_enc(128'd0);
          tmask = sm4_enc({nonce, 32'd1});
          ghash = 0; ctr = 2; aad_len = 0; txt_len = 0;
        end
        sm4g_pkg::ACT_AAD: if (cnt != 0) begin
          ghash = gmul(ghash ^ blk, h_key);
          aad_len += cnt;
        end
        sm4g_pkg::ACT_TEXT: begin
          ct = 0;
          if (cnt != 0) begin
            ks = sm4_enc({nonce, ctr});
            ct = (blk ^ ks) & byte_mask(cnt);
            ghash = gmul(ghash ^ (decrypt ? blk : ct), h_key);
            ctr++;
            txt_len += cnt;
          end
          r.data = ct; r.is_tag = 0; r.match = 0;
          pending_q.push_back(r);
        end
        default: begin
          ghash = gmul(ghash ^ {aad_len << 3, txt_len << 3}, h_key);
          r.data = ghash ^ tmask; r.is_tag = 1;
          r.match = decrypt && (r.data == {bh, bl});
          pending_q.push_back(r);
        end
      endcase
    endfunction

    function void check(bit [127:0] td, bit [1:0] tu);
      gcm_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result data=%h user=%b", $time, td, tu);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (td[63:0] !== e.data[127:64]) begin
        $display("%0t: out_high exp %h got %h", $time, e.data[127:64], td[63:0]); errors++;
      end
      if (td[127:64] !== e.data[63:0]) begin
        $display("%0t: out_low exp %h got %h", $time, e.data[63:0], td[127:64]); errors++;
      end
      if (tu[0] !== e.is_tag) begin
        $display("%0t: is_tag exp %b got %b", $time, e.is_tag, tu[0]); errors++;
      end
      if (tu[1] !== e.match) begin
        $display("%0t: tag_match exp %b got %b", $time, e.match, tu[1]); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;   // block_high, block_low, byte_count, zero pad
  logic [1:0]   in_tuser = '0;   // action
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;       // out_high, out_low
  logic [1:0]   out_tuser;       // is_tag, tag_match
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  sm4_gcm_authenticated_cipher_top dut (.*);

  gcm_scoreboard sb = new();
  int send_idle_pct  = 0;   // sender gap probability, percent
  int recv_stall_pct = 0;   // receiver stall probability, percent
  bit hold_req = 0;         // ask receiver for a long hold-off
  int hold_left = 0;
  int cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata, out_tuser);
  end

  function automatic bit [63:0] pick64();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return ~64'd0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one input transaction; leaves valid high so the next one can follow
  task automatic send(bit [1:0] act, bit [63:0] bh, bit [63:0] bl, bit [4:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= act;
    in_tdata  <= {3'd0, cnt, bl, bh};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(act, bh, bl, cnt);
    @(negedge clk);
  endtask

  // sender stops until every result is back and the engine has gone quiet
  task automatic drain();
    in_tvalid <= 0;
    @(negedge clk);
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // write enable stays high across back-to-back writes; setup drops it
  task automatic write_cfg(bit [2:0] idx, bit [63:0] val);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic setup(bit [63:0] kh, bit [63:0] kl, bit [63:0] nh, bit [31:0] nl, bit dec);
    drain();
    write_cfg(sm4g_pkg::REG_KEY_HIGH, kh);
    write_cfg(sm4g_pkg::REG_KEY_LOW, kl);
    write_cfg(sm4g_pkg::REG_NONCE_HIGH, nh);
    write_cfg(sm4g_pkg::REG_NONCE_LOW, {32'd0, nl});
    write_cfg(sm4g_pkg::REG_DECRYPT, {63'd0, dec});
    cfg_we <= 0;
  endtask

  task automatic finish_item();
    bit [127:0] t;
    t = {pick64(), pick64()};
    // in decrypt mode offer the right tag most of the time
    if (sb.decrypt && $urandom_range(2) != 0) t = sb.next_tag();
    send(sm4g_pkg::ACT_FINISH, t[127:64], t[63:0], 5'($urandom));
  endtask

  // well-formed message with random content, sometimes broken by noise
  task automatic message();
    int n_aad, n_txt;
    n_aad = $urandom_range(0, 3);
    n_txt = $urandom_range(0, 6);
    send(sm4g_pkg::ACT_START, pick64(), pick64(), 5'($urandom));
    for (int i = 0; i < n_aad; i++)
      send(sm4g_pkg::ACT_AAD, pick64(), pick64(), (i == n_aad - 1) ? 5'($urandom) : 5'd16);
    for (int i = 0; i < n_txt; i++) begin
      if ($urandom_range(9) == 0)
        send(2'($urandom_range(1, 3)), pick64(), pick64(), 5'($urandom));
      send(sm4g_pkg::ACT_TEXT, pick64(), pick64(),
           (i == n_txt - 1) ? 5'($urandom) : 5'd16);
    end
    finish_item();
    if ($urandom_range(7) == 0) finish_item();   // repeated finish
  endtask

  int sent_items;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: extreme key and nonce, encrypt
    setup(~64'd0, ~64'd0, ~64'd0, ~32'd0, 0);
    send(sm4g_pkg::ACT_START, 64'd0, 64'd0, 5'd0);
    send(sm4g_pkg::ACT_AAD, ~64'd0, ~64'd0, 5'd16);
    send(sm4g_pkg::ACT_AAD, ~64'd0, ~64'd0, 5'd0);        // empty aad: no effect
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd16);
    send(sm4g_pkg::ACT_TEXT, 64'd0, 64'd0, 5'd16);
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd0);       // empty text: zero result
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd31);      // count saturates to 16
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd1);
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd8);
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd9);
    send(sm4g_pkg::ACT_TEXT, ~64'd0, ~64'd0, 5'd15);
    send(sm4g_pkg::ACT_FINISH, 64'd0, 64'd0, 5'd0);
    send(sm4g_pkg::ACT_FINISH, ~64'd0, ~64'd0, 5'd16);    // repeated finish
    // directed: zero key and nonce, decrypt with a matching tag
    setup(64'd0, 64'd0, 64'd0, 32'd0, 1);
    send(sm4g_pkg::ACT_START, ~64'd0, ~64'd0, 5'd31);
    send(sm4g_pkg::ACT_AAD, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd5);
    send(sm4g_pkg::ACT_TEXT, 64'hdeadbeefcafef00d, 64'h0badc0de12345678, 5'd17);
    send(sm4g_pkg::ACT_TEXT, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 5'd12);
    begin : good_tag
      bit [127:0] t;
      t = sb.next_tag();
      send(sm4g_pkg::ACT_FINISH, t[127:64], t[63:0], 5'd16);
    end
    send(sm4g_pkg::ACT_FINISH, 64'd0, 64'd0, 5'd0);       // now a mismatch

    // random phases: none, sender idle, receiver stall, both light
    sent_items = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      setup(pick64(), pick64(), pick64(), (ph == 5) ? 32'd0 : $urandom, ph[0]);
      if (ph == 2) begin
        hold_req = 1;   // block backs up while sender keeps offering
      end
      while (sent_items < (ph + 1) * 112) begin
        message();
        sent_items += 7;
      end
    end

    drain();
    send_idle_pct = 0;
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
